/* src/dsp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Date string parser package
// Shared types, codes and calendar helpers for the date string parser.
// ----------------------------------------------------------------------------
package dsp_pkg;

    localparam int QDEPTH = 2;

    // Result status codes.
    localparam logic [1:0] ST_ACCEPT    = 2'd0;
    localparam logic [1:0] ST_NODIGIT   = 2'd1;
    localparam logic [1:0] ST_INVALID   = 2'd2;
    localparam logic [1:0] ST_UNDECIDED = 2'd3;

    // Register index of the configuration port.
    localparam logic REG_CURRENT_YEAR = 1'b0;

    localparam logic [11:0] ACC_MAX = 12'd4095;

    typedef enum logic [6:0] {
        PH_START = 7'b0000001,
        PH_MONTH = 7'b0000010,
        PH_SEP1  = 7'b0000100,
        PH_DAY   = 7'b0001000,
        PH_SEP2  = 7'b0010000,
        PH_YEAR  = 7'b0100000,
        PH_DONE  = 7'b1000000
    } phase_t;

    // One classified string byte as it sits in the queue.
    typedef struct packed {
        logic       is_digit;
        logic       is_sep;
        logic       is_zero;
        logic [3:0] digit;
    } byte_class_t;

    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] len;
        begin
            case (m) inside
                4'd1:                         len = 5'd29;
                4'd3, 4'd5, 4'd8, 4'd10:      len = 5'd30;
                default:                      len = 5'd31;
            endcase
            return len;
        end
    endfunction

    // The year is counted from 1900 and never exceeds 2411, so the only
    // century years in reach are 1900 through 2400; of those, 2000 and 2400
    // are leap years.
    function automatic logic is_leap(input logic [8:0] y);
        begin
            return (y[1:0] == 2'b00) && (y != 9'd0) && (y != 9'd200) &&
                   (y != 9'd300) && (y != 9'd400);
        end
    endfunction

    function automatic logic date_bad(input logic [3:0] m, input logic [4:0] d,
                                      input logic [8:0] y);
        begin
            return (d > month_len(m)) ||
                   ((m == 4'd1) && (d == 5'd29) && !is_leap(y));
        end
    endfunction

endpackage

/* src/dsp_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Date string parser front end
// Accepts string bytes, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module dsp_front
    import dsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,      // [7:0] ch
    output logic        q_valid,
    output byte_class_t q_head,
    input  logic        q_pop
);

    byte_class_t q_reg [QDEPTH];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        push;
    byte_class_t cls;

    always_comb
    begin
        cls.is_digit = (s_tdata >= 8'h30) && (s_tdata <= 8'h39);
        cls.is_sep   = (s_tdata == 8'h2F) || (s_tdata == 8'h2D) || (s_tdata == 8'h2E) ||
                       (s_tdata == 8'h3B) || (s_tdata == 8'h2C) || (s_tdata == 8'h5F);
        cls.is_zero  = (s_tdata == 8'h00);
        cls.digit    = s_tdata[3:0];
    end

    assign s_tready = (count_reg != 2'(QDEPTH));
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_head   = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'(QDEPTH))
        else $error("queue count beyond depth");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> count_reg != 2'd0)
        else $error("pop from empty queue");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !q_pop) |=> count_reg == $past(count_reg) + 2'd1)
        else $error("queue count did not grow on push");

endmodule

/* src/dsp_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Date string parser back end
// Runs the month/day/year state machine on classified bytes and registers
// one result per string at its terminator.
// ----------------------------------------------------------------------------
module dsp_back
    import dsp_pkg::*;
#(
    parameter int MAX_OFFSET = 255
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [8:0]  current_year,
    input  logic        q_valid,
    input  byte_class_t q_head,
    output logic        q_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata     // [1:0] status, [5:2] month, [10:6] day,
                                    // [19:11] year, [27:20] stop_offset
);

    localparam int POS_W = $clog2(MAX_OFFSET + 1);

    phase_t           phase_reg, phase_next;
    logic [11:0]      acc_reg, acc_next;
    logic [3:0]       month_reg, month_next;
    logic [4:0]       day_reg, day_next;
    logic [8:0]       year_reg, year_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] stop_reg, stop_next;
    logic [1:0]       status_reg, status_next;

    logic             out_valid_reg, out_valid_next;
    logic [1:0]       out_status_reg;
    logic [3:0]       out_month_reg;
    logic [4:0]       out_day_reg;
    logic [8:0]       out_year_reg;
    logic [7:0]       out_stop_reg;

    logic [15:0]      acc_mul;
    logic [11:0]      acc_sat;
    logic [1:0]       final_status;
    logic [POS_W+7:0] stop_ext;

    assign q_pop = q_valid && (!q_head.is_zero || !out_valid_reg || m_tready);

    always_comb
    begin
        acc_mul = 16'(acc_reg) * 16'd10 + 16'(q_head.digit);
        acc_sat = (acc_mul > 16'(ACC_MAX)) ? ACC_MAX : acc_mul[11:0];
    end

    always_comb
    begin
        phase_next  = phase_reg;
        acc_next    = acc_reg;
        month_next  = month_reg;
        day_next    = day_reg;
        year_next   = year_reg;
        stop_next   = stop_reg;
        status_next = status_reg;
        pos_next    = (pos_reg < POS_W'(MAX_OFFSET)) ? pos_reg + POS_W'(1) : pos_reg;

        unique case (phase_reg) inside
            PH_START:
            begin
                if (q_head.is_digit)
                begin
                    acc_next   = 12'(q_head.digit);
                    phase_next = PH_MONTH;
                end
                else
                begin
                    stop_next   = '0;
                    status_next = ST_NODIGIT;
                    phase_next  = PH_DONE;
                end
            end
            PH_MONTH:
            begin
                if (q_head.is_digit)
                begin
                    acc_next = acc_sat;
                end
                else
                begin
                    stop_next  = pos_reg;
                    phase_next = PH_DONE;
                    if (acc_reg < 12'd1 || acc_reg > 12'd12)
                    begin
                        status_next = ST_INVALID;
                    end
                    else
                    begin
                        month_next = 4'(acc_reg - 12'd1);
                        if (q_head.is_zero)
                        begin
                            day_next    = 5'd1;
                            year_next   = current_year;
                            status_next = date_bad(month_next, day_next, year_next)
                                          ? ST_INVALID : ST_ACCEPT;
                        end
                        else if (q_head.is_sep)
                        begin
                            phase_next = PH_SEP1;
                        end
                        else
                        begin
                            status_next = ST_INVALID;
                        end
                    end
                end
            end
            PH_SEP1, PH_SEP2:
            begin
                if (q_head.is_digit)
                begin
                    acc_next   = 12'(q_head.digit);
                    phase_next = (phase_reg == PH_SEP1) ? PH_DAY : PH_YEAR;
                end
                else
                begin
                    status_next = ST_INVALID;
                    phase_next  = PH_DONE;
                end
            end
            PH_DAY:
            begin
                if (q_head.is_digit)
                begin
                    acc_next = acc_sat;
                end
                else
                begin
                    stop_next  = pos_reg;
                    phase_next = PH_DONE;
                    if (acc_reg < 12'd1 || acc_reg > 12'd31)
                    begin
                        status_next = ST_INVALID;
                    end
                    else
                    begin
                        day_next = acc_reg[4:0];
                        if (q_head.is_zero)
                        begin
                            year_next   = current_year;
                            status_next = date_bad(month_next, day_next, year_next)
                                          ? ST_INVALID : ST_ACCEPT;
                        end
                        else if (q_head.is_sep)
                        begin
                            phase_next = PH_SEP2;
                        end
                        else
                        begin
                            status_next = ST_INVALID;
                        end
                    end
                end
            end
            PH_YEAR:
            begin
                if (q_head.is_digit)
                begin
                    acc_next = acc_sat;
                end
                else
                begin
                    stop_next  = pos_reg;
                    phase_next = PH_DONE;
                    if (acc_reg >= 12'd1900 && acc_reg <= 12'd2399)
                    begin
                        year_next   = 9'(acc_reg - 12'd1900);
                        status_next = date_bad(month_next, day_next, year_next)
                                      ? ST_INVALID : ST_ACCEPT;
                    end
                    else if (acc_reg < 12'd100)
                    begin
                        // Two-digit years below 80 belong to the 2000s.
                        year_next   = (acc_reg < 12'd80) ? 9'(acc_reg + 12'd100)
                                                         : acc_reg[8:0];
                        status_next = date_bad(month_next, day_next, year_next)
                                      ? ST_INVALID : ST_ACCEPT;
                    end
                    else
                    begin
                        status_next = ST_INVALID;
                    end
                end
            end
            PH_DONE:
            begin
                phase_next = PH_DONE;
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase
    end

    always_comb
    begin
        final_status   = (status_next == ST_UNDECIDED) ? ST_INVALID : status_next;
        stop_ext       = {8'd0, stop_next};
        out_valid_next = out_valid_reg && !m_tready;
        if (q_pop && q_head.is_zero)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            acc_reg       <= '0;
            month_reg     <= '0;
            day_reg       <= 5'd1;
            year_reg      <= '0;
            pos_reg       <= '0;
            stop_reg      <= '0;
            status_reg    <= ST_UNDECIDED;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (q_pop)
            begin
                if (q_head.is_zero)
                begin
                    // The terminator closes the string; start over.
                    phase_reg  <= PH_START;
                    acc_reg    <= '0;
                    month_reg  <= '0;
                    day_reg    <= 5'd1;
                    year_reg   <= '0;
                    pos_reg    <= '0;
                    stop_reg   <= '0;
                    status_reg <= ST_UNDECIDED;
                end
                else
                begin
                    phase_reg  <= phase_next;
                    acc_reg    <= acc_next;
                    month_reg  <= month_next;
                    day_reg    <= day_next;
                    year_reg   <= year_next;
                    pos_reg    <= pos_next;
                    stop_reg   <= stop_next;
                    status_reg <= status_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && q_head.is_zero)
        begin
            out_status_reg <= final_status;
            out_month_reg  <= (final_status == ST_ACCEPT) ? month_next : 4'd0;
            out_day_reg    <= (final_status == ST_ACCEPT) ? day_next : 5'd0;
            out_year_reg   <= (final_status == ST_ACCEPT) ? year_next : 9'd0;
            out_stop_reg   <= stop_ext[7:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_stop_reg, out_year_reg, out_day_reg, out_month_reg,
                       out_status_reg};

    a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(phase_reg))
        else $error("parser phase not one-hot");

    a_accept_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == ST_ACCEPT) |->
            (out_month_reg < 4'd12 && out_day_reg != 5'd0))
        else $error("accepted date with out-of-range fields");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |-> !(q_pop && q_head.is_zero))
        else $error("result overwritten while stalled");

endmodule

/* src/date_string_parser_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Date string parser unit
// Parses month[sep day[sep year]] from a zero-terminated byte stream.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while results are taken; the classify queue
// and the parser each handle one byte per cycle. An accepted byte is registered
// in the queue, and a zero byte's result is registered and valid on m_tdata
// once it leaves the queue. A zero byte waits in the queue while an earlier
// result is not taken; the input stalls once two bytes wait. Reset clears
// current_year to 0, empties the queue and puts the parser at string start.
module date_string_parser_unit
    import dsp_pkg::*;
#(
    parameter int MAX_OFFSET = 255
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] ch
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [1:0] status, [5:2] month, [10:6] day,
                                    // [19:11] year, [27:20] stop_offset
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [8:0]  current_year_reg;
    logic        q_valid;
    logic        q_pop;
    byte_class_t q_head;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_CURRENT_YEAR) ? {23'd0, current_year_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_year_reg <= 9'd0;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == REG_CURRENT_YEAR)
        begin
            current_year_reg <= pwdata[8:0];
        end
    end

    dsp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_valid  (q_valid),
        .q_head   (q_head),
        .q_pop    (q_pop)
    );

    dsp_back #(
        .MAX_OFFSET (MAX_OFFSET)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .current_year (current_year_reg),
        .q_valid      (q_valid),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Date string parser testbench
// Feeds zero-terminated strings into the parser, directed cases first and then
// random dates, broken dates and noise, under three back-pressure profiles and
// several default years. A local parser predicts every result, and the monitor
// compares each returned result field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;
    import dsp_pkg::*;

    localparam int MAX_OFFSET = 255;

    typedef struct {
        logic [1:0] status;
        logic [3:0] month;
        logic [4:0] day;
        logic [8:0] year;
        logic [7:0] stop_offset;
    } date_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;      // [7:0] ch
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;             // [1:0] status, [5:2] month, [10:6] day,
                                      // [19:11] year, [27:20] stop_offset
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // Bytes waiting to be sent and dates still owed by the block.
    logic [7:0]   pending_bytes [$];
    date_result_t expected_dates [$];

    int  fail_count = 0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    logic hold_rx = 1'b0;
    logic s_fire = 1'b0;

    // Local copy of the parser state.
    logic [8:0]  default_year;
    phase_t      parse_phase;
    int unsigned number_acc;
    logic [3:0]  month_val;
    logic [4:0]  day_val;
    logic [8:0]  year_val;
    logic [7:0]  byte_pos;
    logic [7:0]  stop_pos;
    logic [1:0]  verdict;
    int          days_in_month [12] = '{31, 29, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    date_string_parser_unit #(.MAX_OFFSET(MAX_OFFSET)) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #1 clk = ~clk;

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("ERROR: %s", msg);
    endtask

    // ------------------------------------------------------------------------
    // Date predictor
    // ------------------------------------------------------------------------
    function automatic logic char_is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic char_is_sep(input logic [7:0] c);
        return (c == "/") || (c == "-") || (c == ".") || (c == ";") ||
               (c == ",") || (c == "_");
    endfunction

    function automatic void clear_parse();
        parse_phase = PH_START;
        number_acc = 0;
        month_val = 4'd0;
        day_val = 5'd1;
        year_val = 9'd0;
        byte_pos = 8'd0;
        stop_pos = 8'd0;
        verdict = ST_UNDECIDED;
    endfunction

    function automatic void give_up(input logic [1:0] code);
        verdict = code;
        parse_phase = PH_DONE;
    endfunction

    function automatic void add_digit(input logic [7:0] c);
        int unsigned v;
        v = number_acc * 10 + (c - "0");
        number_acc = (v > ACC_MAX) ? ACC_MAX : v;
    endfunction

    // Full Gregorian rule on the calendar year.
    function automatic void judge_date();
        int unsigned full_year;
        logic        leap;
        int unsigned m;
        full_year = year_val + 1900;
        leap = (full_year % 4 == 0) && ((full_year % 100 != 0) || (full_year % 400 == 0));
        m = month_val % 12;
        if (day_val > days_in_month[m] || (m == 1 && day_val == 29 && !leap))
            verdict = ST_INVALID;
        else
            verdict = ST_ACCEPT;
        parse_phase = PH_DONE;
    endfunction

    function automatic void parse_byte(input logic [7:0] c);
        logic [7:0]   p;
        int unsigned  a;
        logic [1:0]   st;
        date_result_t r;
        p = byte_pos;
        if (byte_pos < MAX_OFFSET)
            byte_pos++;
        case (parse_phase) inside
            PH_START:
                if (char_is_digit(c))
                begin
                    number_acc = c - "0";
                    parse_phase = PH_MONTH;
                end
                else
                begin
                    stop_pos = 8'd0;
                    give_up(ST_NODIGIT);
                end
            PH_MONTH:
                if (char_is_digit(c))
                    add_digit(c);
                else
                begin
                    stop_pos = p;
                    a = number_acc;
                    if (a < 1 || a > 12)
                        give_up(ST_INVALID);
                    else
                    begin
                        month_val = 4'(a - 1);
                        if (c == 8'd0)
                        begin
                            day_val = 5'd1;
                            year_val = default_year;
                            judge_date();
                        end
                        else if (char_is_sep(c))
                            parse_phase = PH_SEP1;
                        else
                            give_up(ST_INVALID);
                    end
                end
            PH_SEP1, PH_SEP2:
                if (char_is_digit(c))
                begin
                    number_acc = c - "0";
                    parse_phase = (parse_phase == PH_SEP1) ? PH_DAY : PH_YEAR;
                end
                else
                    give_up(ST_INVALID);
            PH_DAY:
                if (char_is_digit(c))
                    add_digit(c);
                else
                begin
                    stop_pos = p;
                    a = number_acc;
                    if (a < 1 || a > 31)
                        give_up(ST_INVALID);
                    else
                    begin
                        day_val = 5'(a);
                        if (c == 8'd0)
                        begin
                            year_val = default_year;
                            judge_date();
                        end
                        else if (char_is_sep(c))
                            parse_phase = PH_SEP2;
                        else
                            give_up(ST_INVALID);
                    end
                end
            PH_YEAR:
                if (char_is_digit(c))
                    add_digit(c);
                else
                begin
                    stop_pos = p;
                    a = number_acc;
                    if (a >= 1900 && a <= 2399)
                    begin
                        year_val = 9'(a - 1900);
                        judge_date();
                    end
                    else if (a >= 80 && a <= 99)
                    begin
                        year_val = 9'(a);
                        judge_date();
                    end
                    else if (a < 80)
                    begin
                        year_val = 9'(a + 100);
                        judge_date();
                    end
                    else
                        give_up(ST_INVALID);
                end
            default:
                parse_phase = PH_DONE;
        endcase

        if (c == 8'd0)
        begin
            st = (verdict == ST_UNDECIDED) ? ST_INVALID : verdict;
            r.status = st;
            r.month = (st == ST_ACCEPT) ? month_val : 4'd0;
            r.day = (st == ST_ACCEPT) ? day_val : 5'd0;
            r.year = (st == ST_ACCEPT) ? year_val : 9'd0;
            r.stop_offset = stop_pos;
            expected_dates.push_back(r);
            clear_parse();
        end
    endfunction

    // ------------------------------------------------------------------------
    // Driver: requests and receiver readiness change on the falling edge.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!s_tvalid || s_fire)
        begin
            if (pending_bytes.size() > 0 && $urandom_range(99, 0) >= send_idle_pct)
            begin
                s_tvalid <= 1'b1;
                s_tdata <= pending_bytes[0];
            end
            else
                s_tvalid <= 1'b0;
        end
        m_tready <= !hold_rx && ($urandom_range(99, 0) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------------
    // Monitor: accepted requests feed the predictor, results are checked.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        date_result_t want;
        date_result_t got;
        if (rst_n)
        begin
            s_fire = s_tvalid && s_tready;
            if (s_fire)
            begin
                parse_byte(s_tdata);
                void'(pending_bytes.pop_front());
            end
            if (m_tvalid && m_tready)
            begin
                got.status = m_tdata[1:0];
                got.month = m_tdata[5:2];
                got.day = m_tdata[10:6];
                got.year = m_tdata[19:11];
                got.stop_offset = m_tdata[27:20];
                if (expected_dates.size() == 0)
                    note_failure($sformatf("unexpected result %h", m_tdata));
                else
                begin
                    want = expected_dates.pop_front();
                    if (got.status !== want.status || got.month !== want.month ||
                        got.day !== want.day || got.year !== want.year ||
                        got.stop_offset !== want.stop_offset)
                        note_failure({
                            $sformatf("expected st=%0d m=%0d d=%0d y=%0d stop=%0d, ",
                                      want.status, want.month, want.day, want.year,
                                      want.stop_offset),
                            $sformatf("got st=%0d m=%0d d=%0d y=%0d stop=%0d",
                                      got.status, got.month, got.day, got.year,
                                      got.stop_offset)});
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic write_current_year(input logic [8:0] value);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {REG_CURRENT_YEAR, 2'b00};
        pwdata <= {23'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        default_year = value;
        @(negedge clk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata[8:0] !== value)
            note_failure($sformatf("current_year read back expected %0d, got %0d",
                                   value, prdata[8:0]));
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            pending_bytes.push_back(s[i]);
        pending_bytes.push_back(8'd0);
    endtask

    task automatic push_decimal(input int unsigned v, input int min_digits);
        logic [7:0]  digs [$];
        int unsigned x;
        x = v;
        do
        begin
            digs.push_front(8'("0" + x % 10));
            x = x / 10;
        end
        while (x != 0);
        while (digs.size() < min_digits)
            digs.push_front("0");
        foreach (digs[i])
            pending_bytes.push_back(digs[i]);
    endtask

    function automatic logic [7:0] random_sep();
        case ($urandom_range(5, 0))
            0: return "/";
            1: return "-";
            2: return ".";
            3: return ";";
            4: return ",";
            default: return "_";
        endcase
    endfunction

    function automatic logic [7:0] random_non_digit();
        logic [7:0] c;
        do c = 8'($urandom_range(255, 1)); while (char_is_digit(c));
        return c;
    endfunction

    task automatic push_day();
        int d;
        case ($urandom_range(9, 0)) inside
            0: d = $urandom_range(40, 0);
            1, 2, 3: d = $urandom_range(31, 28);
            default: d = $urandom_range(28, 1);
        endcase
        push_decimal(d, ($urandom_range(3, 0) == 0) ? 2 : 1);
    endtask

    task automatic push_year();
        case ($urandom_range(9, 0)) inside
            0, 1, 2, 3: push_decimal($urandom_range(99, 0), 2);
            4, 5, 6, 7: push_decimal($urandom_range(2399, 1900), 4);
            8: push_decimal($urandom_range(2600, 1800), 4);
            default: push_decimal($urandom_range(99999, 0), $urandom_range(6, 1));
        endcase
    endtask

    // Long run of leading zeros can push the stop point past the saturation limit.
    task automatic push_long_string();
        int n;
        n = $urandom_range(300, 250);
        repeat (n) pending_bytes.push_back("0");
        push_decimal($urandom_range(12, 1), 1);
        pending_bytes.push_back(random_sep());
        push_day();
        pending_bytes.push_back(8'd0);
    endtask

    task automatic push_random_string();
        int kind;
        int n;
        kind = $urandom_range(99, 0);
        if (kind < 86)
        begin
            if ($urandom_range(19, 0) == 0)
                push_decimal($urandom_range(40, 0), 1);
            else
                push_decimal($urandom_range(12, 1), ($urandom_range(3, 0) == 0) ? 2 : 1);
            if (kind >= 72)
            begin
                // Broken sequences: stray bytes and separators with no digit.
                case ($urandom_range(4, 0))
                    0: pending_bytes.push_back(random_non_digit());
                    1:
                    begin
                        pending_bytes.push_back(random_sep());
                        pending_bytes.push_back(random_non_digit());
                    end
                    2: pending_bytes.push_back(random_sep());
                    3:
                    begin
                        pending_bytes.push_back(random_sep());
                        push_day();
                        pending_bytes.push_back(random_non_digit());
                    end
                    default:
                    begin
                        pending_bytes.push_back(random_sep());
                        push_day();
                        pending_bytes.push_back(random_sep());
                        if ($urandom_range(1, 0) == 0)
                            pending_bytes.push_back(random_non_digit());
                    end
                endcase
            end
            else if ($urandom_range(9, 0) != 0)
            begin
                pending_bytes.push_back(random_sep());
                push_day();
                if ($urandom_range(9, 0) >= 3)
                begin
                    pending_bytes.push_back(random_sep());
                    push_year();
                    if ($urandom_range(4, 0) == 0)
                    begin
                        n = $urandom_range(4, 1);
                        repeat (n) pending_bytes.push_back(8'($urandom_range(255, 1)));
                    end
                end
            end
            pending_bytes.push_back(8'd0);
        end
        else if (kind < 99 || $urandom_range(1, 0) == 0)
        begin
            n = $urandom_range(8, 0);
            repeat (n) pending_bytes.push_back(8'($urandom_range(255, 1)));
            pending_bytes.push_back(8'd0);
        end
        else
            push_long_string();
    endtask

    task automatic push_random_bytes(input int budget);
        int start;
        start = pending_bytes.size();
        while (pending_bytes.size() - start < budget)
            push_random_string();
    endtask

    task automatic wait_idle(input int extra);
        while (pending_bytes.size() != 0 || expected_dates.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        default_year = 9'd0;
        clear_parse();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed strings, with year 2000 as the default.
        send_idle_pct = 21;
        recv_idle_pct = 59;
        write_current_year(9'd100);
        push_text("");
        push_text("A");
        push_text("1");
        push_text("12/31");
        push_text("13/1");
        push_text("0/5");
        push_text("2/29");
        push_text("2/29/1900");
        push_text("2/29/2000");
        push_text("2/29/2100");
        push_text("2/29/96");
        push_text("4/31/20");
        push_text("1-2-79");
        push_text("3.4.80");
        push_text("5;6;99");
        push_text("7,8,2399");
        push_text("9_10_1899");
        push_text("10/");
        push_text("10/x");
        push_text("10/1x");
        push_text("11//1");
        push_text("1/1/20xyz");
        push_text("99999/1");
        push_text("12/25/2400");
        pending_bytes.push_back(8'hFF);
        pending_bytes.push_back(8'd0);
        wait_idle(4);

        write_current_year(9'd0);
        push_random_bytes(320);
        wait_idle(4);

        send_idle_pct = 59;
        recv_idle_pct = 21;
        write_current_year(9'd499);
        push_random_bytes(320);
        wait_idle(4);

        // No idling; the receiver holds off early on so the input backs up.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_current_year(9'd511);
        fork
            begin
                hold_rx = 1'b1;
                repeat (300) @(posedge clk);
                hold_rx = 1'b0;
            end
        join_none
        push_long_string();
        push_random_bytes(320);
        wait_idle(8);

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("simulation failed");
        $finish;
    end

endmodule
